// ===== rtl/core/sbd_pkg.sv =====
// Shared types, constants and helper functions for the session report parser.
`default_nettype none

package sbd_pkg;

    localparam int TAG_LEN     = 6;
    localparam int FIELD_COUNT = 6;
    localparam int LAST_FIELD  = FIELD_COUNT - 1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic        report_valid;
        logic [7:0]  origin_status;
        logic [15:0] origin_sequence;
        logic [15:0] terminated_status;
        logic [15:0] terminated_sequence;
        logic [15:0] terminated_length;
        logic [15:0] queued_count;
        logic        message_waiting;
        logic        more_queued;
    } t_result;

    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h2B; // '+'
            3'd1:    c = 8'h53; // 'S'
            3'd2:    c = 8'h42; // 'B'
            3'd3:    c = 8'h44; // 'D'
            3'd4:    c = 8'h49; // 'I'
            3'd5:    c = 8'h58; // 'X'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbd_line_parser.sv =====
// Running parse state for one response line and the result it gives at line end.
`default_nettype none

module sbd_line_parser
    import sbd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_result         o_result
);

    localparam logic [2:0] TAG_END = 3'(TAG_LEN);
    localparam logic [2:0] FN_LAST = 3'(LAST_FIELD);

    logic [2:0]  r_tag_match_pos, n_tag_match_pos;
    logic        r_tag_seen, n_tag_seen;
    logic        r_in_fields, n_in_fields;
    logic [2:0]  r_field_number, n_field_number;
    t_phase      r_phase, n_phase;
    logic        r_negative, n_negative;
    logic [15:0] r_field_values [FIELD_COUNT];
    logic [15:0] n_field_values [FIELD_COUNT];

    logic        is_digit;
    logic [15:0] cur_value;
    logic [15:0] times_ten;
    logic [15:0] digit_value;
    logic [15:0] acc_value;
    logic        take_digit;
    logic        valid;

    assign is_digit    = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign cur_value   = r_field_values[r_field_number];
    assign times_ten   = {cur_value[12:0], 3'b000} + {cur_value[14:0], 1'b0};
    assign digit_value = {12'd0, i_byte[3:0]};
    assign acc_value   = r_negative ? (times_ten - digit_value) : (times_ten + digit_value);

    always_comb begin
        n_tag_match_pos = r_tag_match_pos;
        n_tag_seen      = r_tag_seen;
        n_in_fields     = r_in_fields;
        n_field_number  = r_field_number;
        n_phase         = r_phase;
        n_negative      = r_negative;
        take_digit      = 1'b0;
        for (int i = 0; i < FIELD_COUNT; i++) begin
            n_field_values[i] = r_field_values[i];
        end

        if (i_step) begin
            if (i_byte == CH_NEWLINE) begin
                n_tag_match_pos = '0;
                n_tag_seen      = 1'b0;
                n_in_fields     = 1'b0;
                n_field_number  = '0;
                n_phase         = PH_SKIP;
                n_negative      = 1'b0;
                for (int i = 0; i < FIELD_COUNT; i++) begin
                    n_field_values[i] = '0;
                end
            end else if (!r_tag_seen) begin
                if (r_tag_match_pos < TAG_END && i_byte == tag_char(r_tag_match_pos)) begin
                    n_tag_match_pos = r_tag_match_pos + 3'd1;
                    if (r_tag_match_pos == TAG_END - 3'd1) begin
                        n_tag_seen = 1'b1;
                    end
                end else begin
                    n_tag_match_pos = (i_byte == CH_PLUS) ? 3'd1 : 3'd0;
                end
            end else if (!r_in_fields) begin
                if (i_byte == CH_COLON) begin
                    n_in_fields    = 1'b1;
                    n_field_number = '0;
                    n_phase        = PH_SKIP;
                    n_negative     = 1'b0;
                end
            end else if (i_byte == CH_COMMA && r_field_number < FN_LAST) begin
                n_field_number = r_field_number + 3'd1;
                n_phase        = PH_SKIP;
                n_negative     = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_SKIP: begin
                        if (is_space(i_byte)) begin
                            n_phase = PH_SKIP;
                        end else if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                            n_negative = (i_byte == CH_MINUS);
                            n_phase    = PH_SIGN;
                        end else if (is_digit) begin
                            take_digit = 1'b1;
                            n_phase    = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS: begin
                        if (is_digit) begin
                            take_digit = 1'b1;
                            n_phase    = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DONE: n_phase = PH_DONE;
                    default: n_phase = PH_DONE;
                endcase
                if (take_digit) begin
                    n_field_values[r_field_number] = acc_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_match_pos <= '0;
            r_tag_seen      <= 1'b0;
            r_in_fields     <= 1'b0;
            r_field_number  <= '0;
            r_phase         <= PH_SKIP;
            r_negative      <= 1'b0;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                r_field_values[i] <= '0;
            end
        end else begin
            r_tag_match_pos <= n_tag_match_pos;
            r_tag_seen      <= n_tag_seen;
            r_in_fields     <= n_in_fields;
            r_field_number  <= n_field_number;
            r_phase         <= n_phase;
            r_negative      <= n_negative;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                r_field_values[i] <= n_field_values[i];
            end
        end
    end

    // result as it stands at the line end; all zero unless the report is complete
    assign valid = r_in_fields && (r_field_number == FN_LAST);

    always_comb begin
        o_result                     = '0;
        o_result.report_valid        = valid;
        if (valid) begin
            o_result.origin_status       = r_field_values[0][7:0];
            o_result.origin_sequence     = r_field_values[1];
            o_result.terminated_status   = r_field_values[2];
            o_result.terminated_sequence = r_field_values[3];
            o_result.terminated_length   = r_field_values[4];
            o_result.queued_count        = r_field_values[5];
            o_result.message_waiting     = (r_field_values[2] == 16'd1)
                                           && (r_field_values[4] != 16'd0);
            o_result.more_queued         = o_result.message_waiting
                                           && (r_field_values[5] != 16'd0);
        end
    end

`ifndef SYNTHESIS
    a_fields_need_colon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_fields |-> (r_field_number == 3'd0))
        else $error("field index moved before the colon");

    a_colon_needs_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_fields |-> r_tag_seen)
        else $error("field parsing without tag");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_byte == CH_NEWLINE) |=>
            (!r_tag_seen && !r_in_fields && r_tag_match_pos == 3'd0))
        else $error("line state not cleared at newline");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sbd_session_response_parser.sv =====
// Session report parser top level: input register, line parser, result register.
// A newline is held in the input register, then its result is held in the result register.
// Throughput: one byte per cycle while not stalled, one parse pass per registered byte.
// A newline waits in the input register only while the result register is full and stalled.
// Reset (synchronous, active low) clears the handshake flags and all line parse state.
`default_nettype none

module sbd_session_response_parser
    import sbd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_report_valid,
    output logic [7:0]       o_origin_status,
    output logic [15:0]      o_origin_sequence,
    output logic [15:0]      o_terminated_status,
    output logic [15:0]      o_terminated_sequence,
    output logic [15:0]      o_terminated_length,
    output logic [15:0]      o_queued_count,
    output logic             o_message_waiting,
    output logic             o_more_queued
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;
    t_result    line_result;
    logic       in_newline;
    logic       stage_go;
    logic       in_take;

    assign in_newline = (r_in_byte == CH_NEWLINE);
    // only a newline needs the result register
    assign stage_go   = r_in_valid && !(in_newline && r_out_valid && i_stall);
    assign o_stall    = r_in_valid && !stage_go;
    assign in_take    = i_valid && !o_stall;

    sbd_line_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (stage_go),
        .i_byte   (r_in_byte),
        .o_result (line_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (stage_go) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (stage_go && in_newline) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
        if (stage_go && in_newline) begin
            r_out <= line_result;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_report_valid        = r_out.report_valid;
    assign o_origin_status       = r_out.origin_status;
    assign o_origin_sequence     = r_out.origin_sequence;
    assign o_terminated_status   = r_out.terminated_status;
    assign o_terminated_sequence = r_out.terminated_sequence;
    assign o_terminated_length   = r_out.terminated_length;
    assign o_queued_count        = r_out.queued_count;
    assign o_message_waiting     = r_out.message_waiting;
    assign o_more_queued         = r_out.more_queued;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && in_newline && r_out_valid && i_stall))
        else $error("input stalled without a blocked newline");

    a_newline_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_go && in_newline) |=> o_valid)
        else $error("newline item gave no result");

    a_more_needs_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_more_queued) |-> (o_message_waiting && o_report_valid))
        else $error("more queued flagged without a waiting message");
`endif

endmodule

`default_nettype wire

// ===== sim/sbd_report_check_pkg.sv =====
// Session report checker class: line predictor and in-order result comparison.
`timescale 1ns / 1ps

package sbd_report_check_pkg;

    import sbd_pkg::*;

    localparam logic [8*TAG_LEN-1:0] SESSION_TAG = "+SBDIX";

    class session_report_checker;

        logic [2:0]  tag_pos;
        bit          tag_found;
        bit          after_colon;
        logic [2:0]  field_idx;
        t_phase      phase;
        bit          negative;
        logic [15:0] field_acc[FIELD_COUNT];

        t_result     pending_reports[$];
        int unsigned errors;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            tag_pos     = '0;
            tag_found   = 1'b0;
            after_colon = 1'b0;
            field_idx   = '0;
            phase       = PH_SKIP;
            negative    = 1'b0;
            foreach (field_acc[i]) field_acc[i] = '0;
        endfunction

        // decimal accumulate, wrapping at 16 bits; a '-' field counts downwards
        function void add_digit(logic [7:0] b);
            logic [15:0] d;
            d = {8'd0, b - CH_ZERO};
            if (negative)
                field_acc[field_idx] = field_acc[field_idx] * 16'd10 - d;
            else
                field_acc[field_idx] = field_acc[field_idx] * 16'd10 + d;
        endfunction

        // one accepted byte; a newline queues the report the block should give
        function void take_byte(logic [7:0] b);
            t_result r;
            bit      is_digit;
            bit      is_blank;
            is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
            is_blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
            if (b == CH_NEWLINE) begin
                r = '0;
                if (after_colon && field_idx == LAST_FIELD) begin
                    r.report_valid        = 1'b1;
                    r.origin_status       = field_acc[0][7:0];
                    r.origin_sequence     = field_acc[1];
                    r.terminated_status   = field_acc[2];
                    r.terminated_sequence = field_acc[3];
                    r.terminated_length   = field_acc[4];
                    r.queued_count        = field_acc[5];
                    r.message_waiting     = (field_acc[2] == 16'd1) && (field_acc[4] != 16'd0);
                    r.more_queued         = r.message_waiting && (field_acc[5] != 16'd0);
                end
                pending_reports = {pending_reports, r};
                clear_line();
            end else if (!tag_found) begin
                if (tag_pos < TAG_LEN && b == SESSION_TAG[8*(TAG_LEN-1-tag_pos) +: 8]) begin
                    tag_pos = tag_pos + 3'd1;
                    if (tag_pos == TAG_LEN)
                        tag_found = 1'b1;
                end else begin
                    tag_pos = (b == CH_PLUS) ? 3'd1 : 3'd0;
                end
            end else if (!after_colon) begin
                if (b == CH_COLON) begin
                    after_colon = 1'b1;
                    field_idx   = '0;
                    phase       = PH_SKIP;
                    negative    = 1'b0;
                end
            end else if (b == CH_COMMA && field_idx < LAST_FIELD) begin
                field_idx = field_idx + 3'd1;
                phase     = PH_SKIP;
                negative  = 1'b0;
            end else begin
                case (phase)
                    PH_SKIP: begin
                        if (is_blank) begin
                        end else if (b == CH_PLUS || b == CH_MINUS) begin
                            negative = (b == CH_MINUS);
                            phase    = PH_SIGN;
                        end else if (is_digit) begin
                            add_digit(b);
                            phase = PH_DIGITS;
                        end else begin
                            phase = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS: begin
                        if (is_digit) begin
                            add_digit(b);
                            phase = PH_DIGITS;
                        end else begin
                            phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
            if (want !== seen) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: report with none expected, got %h", $time, got);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("report_valid", want.report_valid, got.report_valid);
            compare_field("origin_status", want.origin_status, got.origin_status);
            compare_field("origin_sequence", want.origin_sequence, got.origin_sequence);
            compare_field("terminated_status", want.terminated_status, got.terminated_status);
            compare_field("terminated_sequence", want.terminated_sequence,
                          got.terminated_sequence);
            compare_field("terminated_length", want.terminated_length, got.terminated_length);
            compare_field("queued_count", want.queued_count, got.queued_count);
            compare_field("message_waiting", want.message_waiting, got.message_waiting);
            compare_field("more_queued", want.more_queued, got.more_queued);
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

    endclass

endpackage

// ===== sim/tb_sbd_session_response_parser.sv =====
// Testbench top: drives response lines through the parser and checks every report.
`timescale 1ns / 1ps

module tb_sbd_session_response_parser;

    import sbd_pkg::*;
    import sbd_report_check_pkg::*;

    localparam int BYTE_TARGET = 1400;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_in_byte = 8'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_report_valid;
    logic [7:0]  o_origin_status;
    logic [15:0] o_origin_sequence;
    logic [15:0] o_terminated_status;
    logic [15:0] o_terminated_sequence;
    logic [15:0] o_terminated_length;
    logic [15:0] o_queued_count;
    logic        o_message_waiting;
    logic        o_more_queued;

    session_report_checker checker_h;
    logic [7:0]  line_buf[$];
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_request = 1'b0;

    sbd_session_response_parser u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_in_byte             (i_in_byte),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_report_valid        (o_report_valid),
        .o_origin_status       (o_origin_status),
        .o_origin_sequence     (o_origin_sequence),
        .o_terminated_status   (o_terminated_status),
        .o_terminated_sequence (o_terminated_sequence),
        .o_terminated_length   (o_terminated_length),
        .o_queued_count        (o_queued_count),
        .o_message_waiting     (o_message_waiting),
        .o_more_queued         (o_more_queued)
    );

    always #1 i_clk = ~i_clk;

    // monitors: sample at the edge, before any update of this step lands
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            checker_h.take_byte(i_in_byte);
        if (i_rst_n && o_valid && !i_stall)
            checker_h.check_report({o_report_valid, o_origin_status, o_origin_sequence,
                                    o_terminated_status, o_terminated_sequence,
                                    o_terminated_length, o_queued_count,
                                    o_message_waiting, o_more_queued});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= idle_on && ($urandom_range(0, 99) < 15);
        end
    end

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_NEWLINE) ? 8'hFF : b;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic wait_reports_drained();
        while (checker_h.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void add_field(bit prefer_one);
        logic [7:0] ws;
        int         n;
        n = $urandom_range(0, 2);
        repeat (n) begin
            ws = 8'($urandom_range(8, 13));
            add_byte((ws == 8'd8 || ws == CH_NEWLINE) ? CH_SPACE : ws);
        end
        n = $urandom_range(0, 19);
        if (n == 0)
            add_byte(CH_PLUS);
        else if (n < 3)
            add_byte(CH_MINUS);
        if (prefer_one && $urandom_range(0, 1) != 0) begin
            add_byte(CH_ZERO + 8'd1);
        end else begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
            repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0)
            add_byte(noise_byte());
    endfunction

    // a report line, well formed or broken in one of a few ways
    function automatic void add_report_line(bit broken);
        int kind;
        int commas;
        int bad_pos;
        kind    = broken ? $urandom_range(0, 2) : 3;
        commas  = (kind == 0) ? $urandom_range(0, 4) : LAST_FIELD;
        bad_pos = (kind == 1) ? $urandom_range(0, TAG_LEN - 1) : TAG_LEN;
        case ($urandom_range(0, 3))
            0: add_text("AT");
            1: add_byte(noise_byte());
            default: begin
            end
        endcase
        for (int i = 0; i < TAG_LEN; i++)
            add_byte((i == bad_pos) ? noise_byte() : SESSION_TAG[8*(TAG_LEN-1-i) +: 8]);
        if ($urandom_range(0, 3) == 0)
            add_byte(CH_SPACE);
        if (kind != 2)
            add_byte(CH_COLON);
        for (int f = 0; f <= commas; f++) begin
            if (f > 0)
                add_byte(CH_COMMA);
            add_field(f == 2);
        end
        if (commas == LAST_FIELD && $urandom_range(0, 4) == 0)
            add_text(",7,8");
        if ($urandom_range(0, 1) != 0)
            add_byte(CH_CR);
        add_byte(CH_NEWLINE);
    endfunction

    initial begin
        int  pick;
        int  n;
        bit  held;
        bit  paused;
        checker_h = new();
        held   = 1'b0;
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        add_text("+SBDIX: 1, 2, 1, 4, 5, 3\n");
        add_text("+SBDIX:255,65535,1,0,65535,0\n");
        add_text("+SBDIX: -1,-2,+3,-0,\t 7,\r-65535\n");
        add_text("+SBDIX:,,,,,\n");
        add_text("+SBDIX:-,+,1,x,99999999,1,2,3\n");
        add_text("A:+SBDIX:1:2,3,1,5,6,7\n");
        add_text("+SBDIX:1,2,3,4\n");
        add_text("++SBDIX:1,1,1,1,1,1\n");
        add_text("+SBDIX\n");
        add_text("\n");
        add_text("+SBD");
        add_byte(8'h00);
        add_text("IX:1,2,3,4,5,6\n");
        add_text("+SBDIX:");
        add_byte(8'hFF);
        add_text("1,2,1,4,5,6");
        add_byte(8'h00);
        add_byte(CH_NEWLINE);
        send_line();
        i_valid <= 1'b0;
        wait_reports_drained();

        while (bytes_sent < BYTE_TARGET) begin
            if (!held && bytes_sent > 300) begin
                // long receiver hold-off while lines keep coming, so the block backs up
                held         = 1'b1;
                hold_request = 1'b1;
                repeat (6) begin
                    add_text("+SBDIX:1,2,1,4,5,6\n\n");
                    send_line();
                end
            end
            if (!paused && bytes_sent > 1000) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                wait_reports_drained();
            end
            idle_on = !(bytes_sent >= 500 && bytes_sent < 800);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                add_report_line(1'b0);
            end else if (pick < 85) begin
                add_report_line(1'b1);
            end else begin
                n = $urandom_range(0, 24);
                repeat (n) add_byte(noise_byte());
                add_byte(CH_NEWLINE);
            end
            send_line();
        end
        i_valid <= 1'b0;
        idle_on = 1'b1;

        wait_reports_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_h.errors == 0 && checker_h.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
